/* rtl/core/pid_heater_control_step_unit_defines.svh */
// Assertion macros used by the heater PID step top level.
`ifndef PID_HEATER_CONTROL_STEP_UNIT_DEFINES_SVH
`define PID_HEATER_CONTROL_STEP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define PHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define PHC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PHC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PHC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/phc_pkg.sv */
// Package: types and constants of the heater PID step unit.
package phc_pkg;
  localparam int unsigned MinIntervalMs = 10;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_STOP   = 2'd1,
    OP_RESET  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_ILIM = 3'd3,
    REG_DMIN = 3'd4,
    REG_DMAX = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        now_ms;
    logic signed [15:0] target_temp;
    logic signed [15:0] measured_temp;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               held;
    logic               stopped;
    logic               reset_done;
  } out_word_t;
endpackage

/* rtl/core/phc_smul.sv */
// Bit-serial signed multiplier: one multiplier bit per cycle.
module phc_smul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [63:0]  a_i,
  input  logic signed [63:0]  b_i,
  output logic                busy_o,
  output logic signed [127:0] p_o
);
  import phc_pkg::*;

  logic [6:0]           cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic signed [127:0]  acc_q, acc_d, mc_q, mc_d;
  logic [63:0]          mp_q, mp_d;

  // Shift-and-add, the top multiplier bit carries negative weight.
  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; acc_d = acc_q; mc_d = mc_q; mp_d = mp_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      mc_d   = 128'(a_i);
      mp_d   = b_i;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        if (cnt_q == 7'd63) acc_d = acc_q - mc_q;
        else                acc_d = acc_q + mc_q;
      end
      mc_d  = mc_q <<< 1;
      mp_d  = mp_q >> 1;
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign busy_o = busy_q;
  assign p_o    = acc_q;
endmodule

/* rtl/core/phc_sdiv.sv */
// Restoring divider on magnitudes, one quotient bit per cycle, signed result.
module phc_sdiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [31:0]        den_i,
  output logic               busy_o,
  output logic signed [63:0] quo_o
);
  import phc_pkg::*;

  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d;
  logic [63:0] q_q, q_d;
  logic [32:0] r_q, r_d, r_sh;
  logic [31:0] den_q, den_d;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; neg_d = neg_q;
    q_d = q_q; r_d = r_q; den_d = den_q;
    r_sh = {r_q[31:0], q_q[63]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = num_i[63];
      q_d    = num_i[63] ? 64'(-num_i) : 64'(num_i);
      r_d    = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      // Shift in next dividend bit, subtract when it fits.
      if (r_sh >= {1'b0, den_q}) begin
        r_d = r_sh - {1'b0, den_q};
        q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = r_sh;
        q_d = {q_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

/* rtl/core/pid_heater_control_step_unit.sv */
// Top level: heater PID step sequencer with serial multiplier and divider.
// Usage:
//  - in_valid_i/in_ready_o take one input word (opcode, time, setpoint,
//    measurement); out_valid_o/out_ready_i return one result word per item.
//  - Configuration: cfg_we_i with cfg_idx_i (0..5) and cfg_data_i, written
//    only while idle.
//  - Stop, reset-error, ignored, stopped and held updates: result valid the
//    cycle after the input word is taken.
//  - A full update runs six serial operations in order, each with a start state
//    and a wait state: the error*dt product on one bit-serial multiplier, the
//    integral step and derivative divisions on one bit-serial divider, and the
//    three gain products on the same multiplier. The sum and output states
//    follow, and the result is then registered in the output register.
//  - One item at a time; a new word is taken once the previous result has
//    left the output register.
//  - Reset clears state, loads register defaults and drops out_valid_o.
//  - While the receiver stalls the result holds in the output register and
//    no further input word is accepted.
`include "pid_heater_control_step_unit_defines.svh"
module pid_heater_control_step_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  phc_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output phc_pkg::out_word_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import phc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EMUL, S_EMULW, S_IDIV, S_IDIVW, S_DDIV, S_DDIVW, S_MP, S_MPW,
    S_MI, S_MIW, S_MD, S_MDW, S_SUM, S_OUT
  } state_e;

  state_e state_q;
  logic signed [31:0] kp_q, ki_q, kd_q, dmin_q, dmax_q;
  logic [30:0]        ilim_q;
  logic signed [47:0] integ_q;
  logic signed [16:0] perr_q, e_q;
  logic [31:0]        stamp_q, dt_q;
  logic signed [31:0] ldrive_q;
  logic               stop_q;
  logic signed [63:0] sum_q;
  logic signed [63:0] edt_q;
  logic signed [31:0] dterm_q;
  logic               out_valid_q;
  out_word_t          out_q;
  out_word_t          imm_word;

  logic               mul_start, mul_busy, div_start, div_busy;
  logic signed [63:0] ma, mb, dnum, quo;
  logic [31:0]        dden;
  logic signed [127:0] prod;

  logic               in_acc;
  logic [31:0]        dt_now;
  logic signed [16:0] e_now;
  logic signed [63:0] inew, prod_fl, dsat;
  logic signed [63:0] acc_cl;
  logic signed [17:0] de;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign dt_now     = in_data_i.now_ms - stamp_q;
  assign e_now      = 17'(in_data_i.target_temp) - 17'(in_data_i.measured_temp);
  assign de         = 18'(e_q) - 18'(perr_q);
  // floor(x/65536) of product is an arithmetic shift.
  assign prod_fl    = 64'(prod >>> 16);

  // Integral update with clamp.
  always_comb begin
    inew = 64'(integ_q) + quo;
    if (inew > $signed({33'd0, ilim_q}))  inew = $signed({33'd0, ilim_q});
    if (inew < -$signed({33'd0, ilim_q})) inew = -$signed({33'd0, ilim_q});
  end

  // Derivative saturation to 32 bits.
  always_comb begin
    dsat = quo;
    if (quo > 64'sd2147483647)  dsat = 64'sd2147483647;
    if (quo < -64'sd2147483648) dsat = -64'sd2147483648;
  end

  always_comb begin
    acc_cl = sum_q;
    if (acc_cl > 64'(dmax_q)) acc_cl = 64'(dmax_q);
    if (acc_cl < 64'(dmin_q)) acc_cl = 64'(dmin_q);
  end

  // Result word for items answered without the arithmetic path.
  always_comb begin
    imm_word = '0;
    unique case (opcode_e'(in_data_i.opcode))
      OP_UPDATE: begin
        if (stop_q) begin
          imm_word.stopped = 1'b1;
        end else if (dt_now < 32'(MinIntervalMs)) begin
          imm_word.drive = ldrive_q;
          imm_word.held  = 1'b1;
        end
      end
      OP_STOP:  imm_word.stopped = 1'b1;
      OP_RESET: imm_word.reset_done = stop_q;
      default:  imm_word.stopped = stop_q;
    endcase
  end

  // Operand selection for shared units.
  always_comb begin
    mul_start = (state_q == S_EMUL) || (state_q == S_MP) || (state_q == S_MI) ||
                (state_q == S_MD);
    div_start = (state_q == S_IDIV) || (state_q == S_DDIV);
    ma = 64'(kp_q);
    mb = 64'(e_q) <<< 10;
    unique case (state_q)
      S_EMUL:  begin ma = 64'(e_q); mb = 64'(dt_q); end
      S_MI:    begin ma = 64'(ki_q); mb = 64'(integ_q); end
      S_MD:    begin ma = 64'(kd_q); mb = 64'(dterm_q); end
      default: begin ma = 64'(kp_q); mb = 64'(e_q) <<< 10; end
    endcase
    if (state_q == S_IDIV) begin
      dnum = edt_q <<< 10;
      dden = 32'd1000;
    end else begin
      dnum = 64'(de) * 64'sd1024000;
      dden = dt_q;
    end
  end

  phc_smul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(ma), .b_i(mb),
    .busy_o(mul_busy), .p_o(prod)
  );

  phc_sdiv u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(dnum), .den_i(dden),
    .busy_o(div_busy), .quo_o(quo)
  );

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kp_q <= '0; ki_q <= '0; kd_q <= '0;
      ilim_q <= 31'd6553600; dmin_q <= '0; dmax_q <= 32'sd6553600;
      integ_q <= '0; perr_q <= '0; stamp_q <= '0; ldrive_q <= '0;
      stop_q <= 1'b0; out_valid_q <= 1'b0;
      e_q <= '0; dt_q <= '0; sum_q <= '0; dterm_q <= '0; out_q <= '0;
      edt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_KP:   kp_q   <= cfg_data_i;
          REG_KI:   ki_q   <= cfg_data_i;
          REG_KD:   kd_q   <= cfg_data_i;
          REG_ILIM: ilim_q <= cfg_data_i[30:0];
          REG_DMIN: dmin_q <= cfg_data_i;
          REG_DMAX: dmax_q <= cfg_data_i;
          default:  ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_acc) begin
          out_q <= imm_word;
          unique case (opcode_e'(in_data_i.opcode))
            OP_UPDATE: begin
              if (stop_q) begin
                out_valid_q <= 1'b1;
              end else begin
                stamp_q <= in_data_i.now_ms;
                dt_q    <= dt_now;
                e_q     <= e_now;
                if (dt_now < 32'(MinIntervalMs)) begin
                  out_valid_q <= 1'b1;
                end else begin
                  state_q <= S_EMUL;
                end
              end
            end
            OP_STOP: begin
              stop_q <= 1'b1;
              out_valid_q <= 1'b1;
            end
            OP_RESET: begin
              if (stop_q) begin
                stop_q <= 1'b0; integ_q <= '0; perr_q <= '0;
                stamp_q <= in_data_i.now_ms;
              end
              out_valid_q <= 1'b1;
            end
            default: begin
              out_valid_q <= 1'b1;
            end
          endcase
        end
        S_EMUL:  state_q <= S_EMULW;
        S_EMULW: if (!mul_busy) begin
          edt_q   <= prod[63:0];
          state_q <= S_IDIV;
        end
        S_IDIV:  state_q <= S_IDIVW;
        S_IDIVW: if (!div_busy) begin
          integ_q <= 48'(inew);
          state_q <= S_DDIV;
        end
        S_DDIV:  state_q <= S_DDIVW;
        S_DDIVW: if (!div_busy) begin
          dterm_q <= 32'(dsat);
          perr_q  <= e_q;
          state_q <= S_MP;
        end
        S_MP:  state_q <= S_MPW;
        S_MPW: if (!mul_busy) begin
          sum_q   <= prod_fl;
          state_q <= S_MI;
        end
        S_MI:  state_q <= S_MIW;
        S_MIW: if (!mul_busy) begin
          sum_q   <= sum_q + prod_fl;
          state_q <= S_MD;
        end
        S_MD:  state_q <= S_MDW;
        S_MDW: if (!mul_busy) begin
          sum_q   <= sum_q + prod_fl;
          state_q <= S_SUM;
        end
        S_SUM: begin
          ldrive_q    <= 32'(acc_cl);
          out_q.drive <= 32'(acc_cl);
          state_q     <= S_OUT;
        end
        S_OUT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PHC_ASSERT_IMP(a_no_acc_busy, clk_i, rst_ni, state_q != S_IDLE, !in_ready_o)
  `PHC_ASSERT_NXT(a_stop_reports, clk_i, rst_ni,
    in_acc && in_data_i.opcode == OP_STOP, out_valid_o && out_data_o.stopped)
  `PHC_ASSERT_IMP(a_units_excl, clk_i, rst_ni, mul_busy, !div_busy)
  `PHC_ASSERT_IMP(a_held_no_stop, clk_i, rst_ni, out_valid_o && out_data_o.held,
    !out_data_o.stopped)
endmodule
